/* sv/assert_macros.svh */
// Assertion macros shared by the maze carver RTL.
// Each macro samples on clk and is disabled while rst_n is low.
// Requires signals named clk and rst_n in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge out of reset.
`define MCB_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// A consequence that must hold in the same cycle as its trigger.
`define MCB_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// A consequence that must hold in the cycle after its trigger.
`define MCB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/mcb_pkg.sv */
// Shared types and constants of the maze carver block.
// Holds the request and response structs, action codes and sequencer states.
// No dependencies.
package mcb_pkg;

    // Command codes of a request.
    localparam logic CMD_STEP = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // Direction codes; each also indexes its wall bit.
    localparam logic [1:0] DIR_NORTH = 2'd0;
    localparam logic [1:0] DIR_WEST  = 2'd1;
    localparam logic [1:0] DIR_SOUTH = 2'd2;
    localparam logic [1:0] DIR_EAST  = 2'd3;

    // Cell entry layout: visited mark above four wall bits (N, W, S, E).
    localparam int          WALL_BITS = 4;
    localparam int          ENT_W     = WALL_BITS + 1;
    localparam int          ENT_VIS   = WALL_BITS;
    localparam logic [3:0]  WALLS_ALL = 4'hF;

    typedef enum logic [2:0] {
        ACT_CARVED     = 3'd0,
        ACT_BLOCKED    = 3'd1,
        ACT_BACKTRACK  = 3'd2,
        ACT_FINISHED   = 3'd3,
        ACT_DONE_AGAIN = 3'd4,
        ACT_READ_REPLY = 3'd5
    } action_t;

    typedef struct packed {
        logic       command;
        logic [1:0] direction;
        logic [2:0] cell_x;
        logic [2:0] cell_y;
    } req_t;

    typedef struct packed {
        action_t    action;
        logic [2:0] pos_x;
        logic [2:0] pos_y;
        logic       wall_north;
        logic       wall_west;
        logic       wall_south;
        logic       wall_east;
        logic       visited;
    } rsp_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ_WAIT,
        ST_MARK,
        ST_SCAN,
        ST_DECIDE,
        ST_CARVE,
        ST_POP,
        ST_FETCH_ISSUE,
        ST_FETCH_WAIT,
        ST_REPORT
    } state_t;

endpackage

/* sv/mcb_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Used for the cell map and the trail stack. No dependencies.
module mcb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, registered.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* sv/mcb_nbr.sv */
// Cell addressing for the maze carver: index of the current cell and of
// its neighbor in a given direction, with an in-grid flag.
// Depends on mcb_pkg for the direction codes.
module mcb_nbr #(
    parameter int GRID_SIDE = 8,
    localparam int CW = $clog2(GRID_SIDE),
    localparam int AW = $clog2(GRID_SIDE * GRID_SIDE)
) (
    input  logic [CW-1:0] x,
    input  logic [CW-1:0] y,
    input  logic [1:0]    dir,
    output logic [AW-1:0] cur_idx,
    output logic          nb_ok,
    output logic [CW-1:0] nb_x,
    output logic [CW-1:0] nb_y,
    output logic [AW-1:0] nb_idx
);

    localparam logic [CW-1:0] LAST = CW'(GRID_SIDE - 1);

    // Step one cell in the chosen direction; stay put when that leaves the grid.
    always_comb
    begin
        nb_x  = x;
        nb_y  = y;
        nb_ok = 1'b0;
        case (dir)
            mcb_pkg::DIR_NORTH:
            begin
                nb_ok = (y != '0);
                nb_y  = y - CW'(1);
            end
            mcb_pkg::DIR_WEST:
            begin
                nb_ok = (x != '0);
                nb_x  = x - CW'(1);
            end
            mcb_pkg::DIR_SOUTH:
            begin
                nb_ok = (y != LAST);
                nb_y  = y + CW'(1);
            end
            default:
            begin
                nb_ok = (x != LAST);
                nb_x  = x + CW'(1);
            end
        endcase
        if (!nb_ok)
        begin
            nb_x = x;
            nb_y = y;
        end
    end

    // Row-major cell indexes.
    assign cur_idx = AW'(int'(y) * GRID_SIDE + int'(x));
    assign nb_idx  = AW'(int'(nb_y) * GRID_SIDE + int'(nb_x));

endmodule

/* sv/maze_carver_backtracker_core.sv */
// Channel | Direction | Handshake             | Payload
// req     | in        | req_valid / req_ready | mcb_pkg::req_t (step or cell read)
// rsp     | out       | rsp_valid / rsp_ready | mcb_pkg::rsp_t (one per request)
//
// One request is worked on at a time. A cell read passes IDLE, READ_WAIT and REPORT; a step
// after the finish passes IDLE, FETCH_WAIT and REPORT. Other steps pass IDLE, MARK, SCAN and
// DECIDE, then REPORT directly, through CARVE, or through POP, FETCH_ISSUE and FETCH_WAIT.
// A step is one cell-map read, four neighbor reads through the single read port, then the writes.
// After reset a clearing pass writes all GRID_SIDE*GRID_SIDE map entries, one per cycle,
// before the first request is taken. A full output register stalls only the completion.
//
// Top level of the maze carver. Depends on mcb_pkg, mcb_ram, mcb_nbr and
// assert_macros.svh.
`include "assert_macros.svh"

module maze_carver_backtracker_core #(
    parameter int GRID_SIDE = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  mcb_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output mcb_pkg::rsp_t rsp
);

    localparam int CW = $clog2(GRID_SIDE);
    localparam int NC = GRID_SIDE * GRID_SIDE;
    localparam int AW = $clog2(NC);
    localparam int DW = $clog2(NC + 1);
    localparam int SW = 2 * CW;
    localparam logic [DW-1:0] NC_D = DW'(NC);

    mcb_pkg::state_t state_reg, state_next;
    logic [AW-1:0]   clr_idx_reg, clr_idx_next;
    logic [CW-1:0]   cur_x_reg, cur_x_next;
    logic [CW-1:0]   cur_y_reg, cur_y_next;
    logic [DW-1:0]   depth_reg, depth_next;
    logic [DW-1:0]   total_reg, total_next;
    logic            finished_reg, finished_next;
    mcb_pkg::req_t   req_reg, req_next;
    logic            rd_ok_reg, rd_ok_next;
    logic [3:0]      cur_walls_reg, cur_walls_next;
    logic [3:0]      nb_walls_reg, nb_walls_next;
    logic [1:0]      scan_reg, scan_next;
    logic            ok_reg, ok_next;
    logic [3:0]      open_reg, open_next;
    mcb_pkg::action_t act_reg, act_next;
    mcb_pkg::rsp_t   res_reg, res_next;
    mcb_pkg::rsp_t   rsp_reg, rsp_next;
    logic            rsp_valid_reg, rsp_valid_next;

    // Cell map port signals.
    logic                      cm_we, cm_re;
    logic [AW-1:0]             cm_waddr, cm_raddr;
    logic [mcb_pkg::ENT_W-1:0] cm_wdata, cm_rdata;

    // Trail stack port signals; entries hold {y, x}.
    logic          st_we, st_re;
    logic [AW-1:0] st_waddr, st_raddr;
    logic [SW-1:0] st_wdata, st_rdata;

    // Addressing.
    logic [1:0]    nb_dir;
    logic [AW-1:0] cur_idx, nb_idx;
    logic          nb_ok;
    logic [CW-1:0] nb_x, nb_y;
    logic [DW-1:0] depth_dec;
    logic          rd_ok;
    logic [AW-1:0] rd_idx;
    logic [1:0]    opp_dir;

    function automatic mcb_pkg::rsp_t make_rsp(mcb_pkg::action_t act, logic [2:0] px,
                                               logic [2:0] py, logic [3:0] walls,
                                               logic vis);
        mcb_pkg::rsp_t r;
        r.action     = act;
        r.pos_x      = px;
        r.pos_y      = py;
        r.wall_north = walls[0];
        r.wall_west  = walls[1];
        r.wall_south = walls[2];
        r.wall_east  = walls[3];
        r.visited    = vis;
        return r;
    endfunction

    mcb_ram #(
        .WIDTH (mcb_pkg::ENT_W),
        .DEPTH (NC)
    ) u_cell_map (
        .clk   (clk),
        .we    (cm_we),
        .waddr (cm_waddr),
        .wdata (cm_wdata),
        .re    (cm_re),
        .raddr (cm_raddr),
        .rdata (cm_rdata)
    );

    mcb_ram #(
        .WIDTH (SW),
        .DEPTH (NC)
    ) u_trail (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .re    (st_re),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    mcb_nbr #(
        .GRID_SIDE (GRID_SIDE)
    ) u_nbr (
        .x       (cur_x_reg),
        .y       (cur_y_reg),
        .dir     (nb_dir),
        .cur_idx (cur_idx),
        .nb_ok   (nb_ok),
        .nb_x    (nb_x),
        .nb_y    (nb_y),
        .nb_idx  (nb_idx)
    );

    // Neighbor direction: the scan walks N, W, S, E; otherwise the request's choice.
    always_comb
    begin
        case (state_reg)
            mcb_pkg::ST_MARK: nb_dir = mcb_pkg::DIR_NORTH;
            mcb_pkg::ST_SCAN: nb_dir = scan_reg + 2'd1;
            default:          nb_dir = req_reg.direction;
        endcase
    end

    assign depth_dec = depth_reg - DW'(1);
    assign opp_dir   = req_reg.direction ^ 2'b10;
    assign rd_ok     = (int'(req.cell_x) < GRID_SIDE) && (int'(req.cell_y) < GRID_SIDE);
    assign rd_idx    = rd_ok ? AW'(int'(req.cell_y) * GRID_SIDE + int'(req.cell_x)) : cur_idx;

    // Sequencer: next state, memory controls and register updates.
    always_comb
    begin
        state_next     = state_reg;
        clr_idx_next   = clr_idx_reg;
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        depth_next     = depth_reg;
        total_next     = total_reg;
        finished_next  = finished_reg;
        req_next       = req_reg;
        rd_ok_next     = rd_ok_reg;
        cur_walls_next = cur_walls_reg;
        nb_walls_next  = nb_walls_reg;
        scan_next      = scan_reg;
        ok_next        = ok_reg;
        open_next      = open_reg;
        act_next       = act_reg;
        res_next       = res_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        req_ready      = 1'b0;

        cm_we    = 1'b0;
        cm_waddr = cur_idx;
        cm_wdata = {1'b1, cur_walls_reg};
        cm_re    = 1'b0;
        cm_raddr = cur_idx;
        st_we    = 1'b0;
        st_waddr = depth_reg[AW-1:0];
        st_wdata = {cur_y_reg, cur_x_reg};
        st_re    = 1'b0;
        st_raddr = depth_dec[AW-1:0];

        case (state_reg)
            // Sweep the cell map to no walls removed, nothing visited.
            mcb_pkg::ST_CLEAR:
            begin
                cm_we        = 1'b1;
                cm_waddr     = clr_idx_reg;
                cm_wdata     = {1'b0, mcb_pkg::WALLS_ALL};
                clr_idx_next = clr_idx_reg + AW'(1);
                if (clr_idx_reg == AW'(NC - 1))
                begin
                    state_next = mcb_pkg::ST_IDLE;
                end
            end

            // Take a request and issue the first cell-map read.
            mcb_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    req_next = req;
                    cm_re    = 1'b1;
                    if (req.command == mcb_pkg::CMD_READ)
                    begin
                        rd_ok_next = rd_ok;
                        cm_raddr   = rd_idx;
                        state_next = mcb_pkg::ST_READ_WAIT;
                    end
                    else if (finished_reg)
                    begin
                        act_next   = mcb_pkg::ACT_DONE_AGAIN;
                        state_next = mcb_pkg::ST_FETCH_WAIT;
                    end
                    else
                    begin
                        state_next = mcb_pkg::ST_MARK;
                    end
                end
            end

            // Cell read reply; cells outside the grid report all walls standing.
            mcb_pkg::ST_READ_WAIT:
            begin
                res_next = make_rsp(mcb_pkg::ACT_READ_REPLY, req_reg.cell_x, req_reg.cell_y,
                                    rd_ok_reg ? cm_rdata[3:0] : mcb_pkg::WALLS_ALL,
                                    rd_ok_reg && cm_rdata[mcb_pkg::ENT_VIS]);
                state_next = mcb_pkg::ST_REPORT;
            end

            // Mark the current cell visited and start the neighbor scan.
            mcb_pkg::ST_MARK:
            begin
                cur_walls_next = cm_rdata[3:0];
                if (!cm_rdata[mcb_pkg::ENT_VIS])
                begin
                    cm_we      = 1'b1;
                    cm_wdata   = {1'b1, cm_rdata[3:0]};
                    total_next = total_reg + DW'(1);
                end
                cm_re      = 1'b1;
                cm_raddr   = nb_idx;
                ok_next    = nb_ok;
                scan_next  = mcb_pkg::DIR_NORTH;
                state_next = mcb_pkg::ST_SCAN;
            end

            // Collect one neighbor per cycle while issuing the next read.
            mcb_pkg::ST_SCAN:
            begin
                open_next[scan_reg] = ok_reg && !cm_rdata[mcb_pkg::ENT_VIS];
                if (scan_reg == req_reg.direction)
                begin
                    nb_walls_next = cm_rdata[3:0];
                end
                if (scan_reg == mcb_pkg::DIR_EAST)
                begin
                    state_next = mcb_pkg::ST_DECIDE;
                end
                else
                begin
                    cm_re     = 1'b1;
                    cm_raddr  = nb_idx;
                    ok_next   = nb_ok;
                    scan_next = scan_reg + 2'd1;
                end
            end

            // Finish, backtrack, carve or report a blocked choice.
            mcb_pkg::ST_DECIDE:
            begin
                if (open_reg == 4'b0000)
                begin
                    if (total_reg >= NC_D)
                    begin
                        finished_next = 1'b1;
                        res_next = make_rsp(mcb_pkg::ACT_FINISHED, 3'(cur_x_reg),
                                            3'(cur_y_reg), cur_walls_reg, 1'b1);
                        state_next = mcb_pkg::ST_REPORT;
                    end
                    else if (depth_reg != '0)
                    begin
                        st_re      = 1'b1;
                        depth_next = depth_dec;
                        state_next = mcb_pkg::ST_POP;
                    end
                    else
                    begin
                        res_next = make_rsp(mcb_pkg::ACT_BACKTRACK, 3'(cur_x_reg),
                                            3'(cur_y_reg), cur_walls_reg, 1'b1);
                        state_next = mcb_pkg::ST_REPORT;
                    end
                end
                else if (open_reg[req_reg.direction])
                begin
                    cm_we    = 1'b1;
                    cm_wdata = {1'b1, cur_walls_reg & ~(4'b0001 << req_reg.direction)};
                    if (depth_reg < NC_D)
                    begin
                        st_we      = 1'b1;
                        depth_next = depth_reg + DW'(1);
                    end
                    state_next = mcb_pkg::ST_CARVE;
                end
                else
                begin
                    res_next = make_rsp(mcb_pkg::ACT_BLOCKED, 3'(cur_x_reg),
                                        3'(cur_y_reg), cur_walls_reg, 1'b1);
                    state_next = mcb_pkg::ST_REPORT;
                end
            end

            // Open the neighbor's facing wall and move into it.
            mcb_pkg::ST_CARVE:
            begin
                cm_we      = 1'b1;
                cm_waddr   = nb_idx;
                cm_wdata   = {1'b0, nb_walls_reg & ~(4'b0001 << opp_dir)};
                cur_x_next = nb_x;
                cur_y_next = nb_y;
                res_next = make_rsp(mcb_pkg::ACT_CARVED, 3'(nb_x), 3'(nb_y),
                                    nb_walls_reg & ~(4'b0001 << opp_dir), 1'b0);
                state_next = mcb_pkg::ST_REPORT;
            end

            // Popped cell becomes current.
            mcb_pkg::ST_POP:
            begin
                cur_x_next = st_rdata[CW-1:0];
                cur_y_next = st_rdata[SW-1:CW];
                act_next   = mcb_pkg::ACT_BACKTRACK;
                state_next = mcb_pkg::ST_FETCH_ISSUE;
            end

            mcb_pkg::ST_FETCH_ISSUE:
            begin
                cm_re      = 1'b1;
                state_next = mcb_pkg::ST_FETCH_WAIT;
            end

            // Report the current cell as it stands in the map.
            mcb_pkg::ST_FETCH_WAIT:
            begin
                res_next = make_rsp(act_reg, 3'(cur_x_reg), 3'(cur_y_reg),
                                    cm_rdata[3:0], cm_rdata[mcb_pkg::ENT_VIS]);
                state_next = mcb_pkg::ST_REPORT;
            end

            // Hand the result to the output register once it is free.
            mcb_pkg::ST_REPORT:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = mcb_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = mcb_pkg::ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mcb_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_idx_reg   <= '0;
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            depth_reg     <= '0;
            total_reg     <= '0;
            finished_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            clr_idx_reg   <= clr_idx_next;
            cur_x_reg     <= cur_x_next;
            cur_y_reg     <= cur_y_next;
            depth_reg     <= depth_next;
            total_reg     <= total_next;
            finished_reg  <= finished_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload and scratch registers.
    always_ff @(posedge clk)
    begin
        req_reg       <= req_next;
        rd_ok_reg     <= rd_ok_next;
        cur_walls_reg <= cur_walls_next;
        nb_walls_reg  <= nb_walls_next;
        scan_reg      <= scan_next;
        ok_reg        <= ok_next;
        open_reg      <= open_next;
        act_reg       <= act_next;
        res_reg       <= res_next;
        rsp_reg       <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Checks on the trail, the finish and the carve; a push happens only in the decide state.
    `MCB_ASSERT_ALWAYS(a_depth_range, depth_reg <= NC_D, "trail depth beyond cell count")
    `MCB_ASSERT_IMPLY(a_finish_total, finished_reg, total_reg == NC_D, "finished early")
    `MCB_ASSERT_IMPLY(a_carve_in_grid, state_reg == mcb_pkg::ST_CARVE, nb_ok, "carve off grid")
    `MCB_ASSERT_NEXT(a_push_depth, st_we, depth_reg == $past(depth_reg) + DW'(1), "push lost")

endmodule
